[rtl/rhwf_pkg.sv]
`default_nettype none

package rhwf_pkg;

   // Grid size and coordinate widths
   localparam int GRID_COLS = 32;
   localparam int GRID_ROWS = 32;
   localparam int COORD_W   = 5;
   localparam int HEAD_W    = 2;
   localparam int POS_LIMIT = 1 << COORD_W;
   localparam int COL_LIMIT = (GRID_COLS < POS_LIMIT) ? GRID_COLS : POS_LIMIT;
   localparam int ROW_LIMIT = (GRID_ROWS < POS_LIMIT) ? GRID_ROWS : POS_LIMIT;
   localparam int COL_AW    = $clog2(GRID_COLS);
   localparam int ROW_AW    = $clog2(GRID_ROWS);

   // Neighbor coordinate: one bit wider so that -1 and +32 fall off the grid
   localparam int NB_W = COORD_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COORD_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HEADING = 3'd4;

   // Headings
   localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd2;
   localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd3;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_RESTART = 2'd1,
      ACT_STEP    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Column of the neighbor in direction h
   function automatic logic [NB_W-1:0] step_x(input logic [COORD_W-1:0] x,
                                               input logic [HEAD_W-1:0] h);
      logic [NB_W-1:0] xe;
      xe = {1'b0, x};
      case (h)
         HEAD_RIGHT: step_x = xe + NB_W'(1);
         HEAD_LEFT:  step_x = xe - NB_W'(1);
         default:    step_x = xe;
      endcase
   endfunction

   // Row of the neighbor in direction h
   function automatic logic [NB_W-1:0] step_y(input logic [COORD_W-1:0] y,
                                               input logic [HEAD_W-1:0] h);
      logic [NB_W-1:0] ye;
      ye = {1'b0, y};
      case (h)
         HEAD_DOWN: step_y = ye + NB_W'(1);
         HEAD_UP:   step_y = ye - NB_W'(1);
         default:   step_y = ye;
      endcase
   endfunction

   function automatic logic in_grid(input logic [NB_W-1:0] x, input logic [NB_W-1:0] y);
      in_grid = (x < NB_W'(COL_LIMIT)) && (y < NB_W'(ROW_LIMIT));
   endfunction

endpackage

`default_nettype wire

[rtl/rhwf_if.sv]
`default_nettype none

// Request channel: one action item per transfer
interface rhwf_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [rhwf_pkg::COORD_W-1:0]  cell_x;
   logic [rhwf_pkg::COORD_W-1:0]  cell_y;
   logic                          cell_open;

   modport source (output valid, action, cell_x, cell_y, cell_open, input ready);
   modport sink   (input valid, action, cell_x, cell_y, cell_open, output ready);
endinterface

// Response channel: walker state after each item
interface rhwf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rhwf_pkg::COORD_W-1:0]  pos_x;
   logic [rhwf_pkg::COORD_W-1:0]  pos_y;
   logic [rhwf_pkg::HEAD_W-1:0]   heading;
   logic                          moved;
   logic                          at_goal;

   modport source (output valid, pos_x, pos_y, heading, moved, at_goal, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, moved, at_goal, output ready);
endinterface

`default_nettype wire

[rtl/rhwf_ram.sv]
`default_nettype none

// Generic RAM: one write port, two registered read ports
module rhwf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

[rtl/right_hand_wall_follower.sv]
// A request transfer starts a row read; the response is registered at the end of the
// update that follows. One item is in flight at a time: the read-modify-write of the
// cell row memory (registered read, then write-back or walker update) finishes first.
// A new request is taken while a finished response is being transferred.
// Reset (synchronous): walker, state, response valid and per-row valid bits clear,
// settings load defaults; rows never written read as walls, so there is no clearing pass.
`default_nettype none

module right_hand_wall_follower (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rhwf_req_if.sink                               req,
   rhwf_rsp_if.source                             rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [rhwf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rhwf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int CW = rhwf_pkg::COORD_W;
   localparam int HW = rhwf_pkg::HEAD_W;
   localparam int RW = rhwf_pkg::ROW_AW;
   localparam int KW = rhwf_pkg::COL_AW;
   localparam int NW = rhwf_pkg::NB_W;

   // Configuration registers
   logic [CW-1:0] goal_x_ff, goal_y_ff, start_x_ff, start_y_ff;
   logic [HW-1:0] start_heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff        <= CW'(16);
         goal_y_ff        <= '0;
         start_x_ff       <= '0;
         start_y_ff       <= CW'(1);
         start_heading_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rhwf_pkg::CSR_GOAL_X:        goal_x_ff        <= csr_wr_data;
            rhwf_pkg::CSR_GOAL_Y:        goal_y_ff        <= csr_wr_data;
            rhwf_pkg::CSR_START_X:       start_x_ff       <= csr_wr_data;
            rhwf_pkg::CSR_START_Y:       start_y_ff       <= csr_wr_data;
            rhwf_pkg::CSR_START_HEADING: start_heading_ff <= csr_wr_data[HW-1:0];
            default: ;
         endcase
      end
   end

   // Control and walker state
   rhwf_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        walker_x_ff, walker_x_in, walker_y_ff, walker_y_in;
   logic [HW-1:0]        walker_head_ff, walker_head_in;
   logic [rhwf_pkg::GRID_ROWS-1:0] row_valid_ff, row_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item captured at transfer; port a carries the written cell or right neighbor
   rhwf_pkg::action_type action_ff;
   logic                 cell_open_ff;
   logic [CW-1:0]        a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic                 a_in_ff, b_in_ff;

   // Response payload register
   logic [CW-1:0]        pos_x_ff, pos_y_ff;
   logic [HW-1:0]        heading_ff;
   logic                 moved_ff, moved_in, at_goal_ff;

   // Transfer decode and neighbor addresses
   logic                 req_xfer;
   rhwf_pkg::action_type req_action;
   logic [HW-1:0]        right_head;
   logic [NW-1:0]        a_x_nb, a_y_nb, b_x_nb, b_y_nb;
   logic [CW-1:0]        rd_row_a, rd_row_b;

   // Memory signals
   logic                 ram_we;
   logic [rhwf_pkg::GRID_COLS-1:0] ram_rdata_a, ram_rdata_b, ram_wdata, row_base;
   logic                 right_open, ahead_open, start_at_goal;

   assign req.ready  = (state_ff == rhwf_pkg::ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_xfer   = req.valid && req.ready;
   assign req_action = rhwf_pkg::action_type'(req.action);
   assign right_head = walker_head_ff + HW'(1);

   // Select the cells to read for this item
   always_comb begin
      if (req_action == rhwf_pkg::ACT_WRITE) begin
         a_x_nb = {1'b0, req.cell_x};
         a_y_nb = {1'b0, req.cell_y};
      end else begin
         a_x_nb = rhwf_pkg::step_x(walker_x_ff, right_head);
         a_y_nb = rhwf_pkg::step_y(walker_y_ff, right_head);
      end
      b_x_nb   = rhwf_pkg::step_x(walker_x_ff, walker_head_ff);
      b_y_nb   = rhwf_pkg::step_y(walker_y_ff, walker_head_ff);
      rd_row_a = a_y_nb[CW-1:0];
      rd_row_b = b_y_nb[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff    <= req_action;
         cell_open_ff <= req.cell_open;
         a_x_ff       <= a_x_nb[CW-1:0];
         a_y_ff       <= a_y_nb[CW-1:0];
         a_in_ff      <= rhwf_pkg::in_grid(a_x_nb, a_y_nb);
         b_x_ff       <= b_x_nb[CW-1:0];
         b_y_ff       <= b_y_nb[CW-1:0];
         b_in_ff      <= rhwf_pkg::in_grid(b_x_nb, b_y_nb);
      end
   end

   rhwf_ram #(
      .WIDTH (rhwf_pkg::GRID_COLS),
      .DEPTH (rhwf_pkg::GRID_ROWS)
   ) u_cells (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (RW'(a_y_ff)),
      .wr_data   (ram_wdata),
      .rd_addr_a (RW'(rd_row_a)),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (RW'(rd_row_b)),
      .rd_data_b (ram_rdata_b)
   );

   // Execute: row write-back or walker update
   always_comb begin
      state_in       = state_ff;
      walker_x_in    = walker_x_ff;
      walker_y_in    = walker_y_ff;
      walker_head_in = walker_head_ff;
      row_valid_in   = row_valid_ff;
      moved_in       = 1'b0;
      ram_we         = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;

      right_open    = a_in_ff && row_valid_ff[RW'(a_y_ff)] && ram_rdata_a[KW'(a_x_ff)];
      ahead_open    = b_in_ff && row_valid_ff[RW'(b_y_ff)] && ram_rdata_b[KW'(b_x_ff)];
      start_at_goal = (walker_x_ff == goal_x_ff) && (walker_y_ff == goal_y_ff);

      // A row never written reads as all walls
      row_base  = row_valid_ff[RW'(a_y_ff)] ? ram_rdata_a : '0;
      ram_wdata = row_base;
      ram_wdata[KW'(a_x_ff)] = cell_open_ff;

      unique case (state_ff)
         rhwf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = rhwf_pkg::ST_EXEC;
            end
         end
         rhwf_pkg::ST_EXEC: begin
            state_in     = rhwf_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            case (action_ff)
               rhwf_pkg::ACT_WRITE: begin
                  if (a_in_ff) begin
                     ram_we                       = 1'b1;
                     row_valid_in[RW'(a_y_ff)]    = 1'b1;
                  end
               end
               rhwf_pkg::ACT_RESTART: begin
                  walker_x_in    = start_x_ff;
                  walker_y_in    = start_y_ff;
                  walker_head_in = start_heading_ff;
               end
               rhwf_pkg::ACT_STEP: begin
                  if (!start_at_goal) begin
                     if (right_open) begin
                        walker_head_in = right_head;
                        walker_x_in    = a_x_ff;
                        walker_y_in    = a_y_ff;
                        moved_in       = 1'b1;
                     end else if (ahead_open) begin
                        walker_x_in    = b_x_ff;
                        walker_y_in    = b_y_ff;
                        moved_in       = 1'b1;
                     end else begin
                        walker_head_in = walker_head_ff - HW'(1);
                     end
                  end
               end
               default: ;
            endcase
         end
         default: state_in = rhwf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rhwf_pkg::ST_IDLE;
         walker_x_ff    <= '0;
         walker_y_ff    <= '0;
         walker_head_ff <= '0;
         row_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walker_x_ff    <= walker_x_in;
         walker_y_ff    <= walker_y_in;
         walker_head_ff <= walker_head_in;
         row_valid_ff   <= row_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload loads at the end of execute
   always_ff @(posedge clock) begin
      if (state_ff == rhwf_pkg::ST_EXEC) begin
         pos_x_ff   <= walker_x_in;
         pos_y_ff   <= walker_y_in;
         heading_ff <= walker_head_in;
         moved_ff   <= moved_in;
         at_goal_ff <= (walker_x_in == goal_x_ff) && (walker_y_in == goal_y_ff);
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.pos_x   = pos_x_ff;
   assign rsp.pos_y   = pos_y_ff;
   assign rsp.heading = heading_ff;
   assign rsp.moved   = moved_ff;
   assign rsp.at_goal = at_goal_ff;

endmodule

`default_nettype wire

[rtl/rhwf_checker.sv]
`default_nettype none

module rhwf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [rhwf_pkg::COORD_W-1:0]   rsp_pos_x,
   input wire logic [rhwf_pkg::COORD_W-1:0]   rsp_pos_y,
   input wire logic [rhwf_pkg::HEAD_W-1:0]    rsp_heading,
   input wire logic                           rsp_moved,
   input wire logic                           rsp_at_goal
);

   // Nothing left to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_heading) && $stable(rsp_moved) && $stable(rsp_at_goal))
      else $error("stalled response changed");

   // One item in flight: no second request and no stale response while it executes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("request taken while an item executes");

   // Every transfer yields a response once its execute state is done
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("missing response");

endmodule

bind right_hand_wall_follower rhwf_checker u_rhwf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_pos_x   (rsp.pos_x),
   .rsp_pos_y   (rsp.pos_y),
   .rsp_heading (rsp.heading),
   .rsp_moved   (rsp.moved),
   .rsp_at_goal (rsp.at_goal)
);

`default_nettype wire

[verif/right_hand_wall_follower_checker.sv]
// Watches both channels and the register port, keeps its own copy of the
// grid and the walker, and compares every response transfer with the
// oldest predicted walker state.
module right_hand_wall_follower_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rhwf_req_if                                    req,
   rhwf_rsp_if                                    rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [rhwf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rhwf_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output int                                     fail_count,
   output int                                     pending_count
);
   import rhwf_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [HEAD_W-1:0]  heading;
      logic               moved;
      logic               at_goal;
   } walker_report_type;

   // Shadow grid, walker and registers
   bit                 cell_map [GRID_ROWS][GRID_COLS];
   logic [COORD_W-1:0] walker_x, walker_y;
   logic [HEAD_W-1:0]  walker_head;
   logic [COORD_W-1:0] goal_x, goal_y, start_x, start_y;
   logic [HEAD_W-1:0]  start_head;

   walker_report_type  walker_q [$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   // Off-grid neighbors read as walls
   function automatic bit cell_is_open(input int x, input int y);
      if (x < 0 || y < 0 || x >= COL_LIMIT || y >= ROW_LIMIT) begin
         return 1'b0;
      end
      return cell_map[y][x];
   endfunction

   function automatic int delta_x(input logic [HEAD_W-1:0] h);
      case (h)
         HEAD_RIGHT: return 1;
         HEAD_LEFT:  return -1;
         default:    return 0;
      endcase
   endfunction

   function automatic int delta_y(input logic [HEAD_W-1:0] h);
      case (h)
         HEAD_DOWN: return 1;
         HEAD_UP:   return -1;
         default:   return 0;
      endcase
   endfunction

   function automatic bit side_open(input logic [HEAD_W-1:0] h);
      return cell_is_open(int'(walker_x) + delta_x(h), int'(walker_y) + delta_y(h));
   endfunction

   function automatic bit on_goal();
      return (walker_x == goal_x) && (walker_y == goal_y);
   endfunction

   // One right-hand-rule item: update the shadow state, return the walker
   task automatic follow_wall(input logic [1:0] act, input logic [COORD_W-1:0] cx,
                              input logic [COORD_W-1:0] cy, input logic copen,
                              output walker_report_type res);
      logic [HEAD_W-1:0] right_head;
      logic              moved;
      moved = 1'b0;
      case (act)
         ACT_WRITE: begin
            if (cx < COL_LIMIT && cy < ROW_LIMIT) begin
               cell_map[cy][cx] = copen;
            end
         end
         ACT_RESTART: begin
            walker_x    = start_x;
            walker_y    = start_y;
            walker_head = start_head;
         end
         ACT_STEP: begin
            if (!on_goal()) begin
               right_head = walker_head + 2'd1;
               if (side_open(right_head)) begin
                  walker_head = right_head;
                  moved       = 1'b1;
               end else if (side_open(walker_head)) begin
                  moved       = 1'b1;
               end else begin
                  walker_head = walker_head - 2'd1;
               end
               if (moved) begin
                  walker_x = COORD_W'(int'(walker_x) + delta_x(walker_head));
                  walker_y = COORD_W'(int'(walker_y) + delta_y(walker_head));
               end
            end
         end
         default: ;
      endcase
      res = '{walker_x, walker_y, walker_head, moved, on_goal()};
   endtask

   always @(posedge clock) begin : monitor
      walker_report_type got, want;
      if (reset) begin
         for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
               cell_map[r][c] = 1'b0;
            end
         end
         walker_x    = '0;
         walker_y    = '0;
         walker_head = HEAD_RIGHT;
         goal_x      = COORD_W'(16);
         goal_y      = '0;
         start_x     = '0;
         start_y     = COORD_W'(1);
         start_head  = HEAD_RIGHT;
         walker_q.delete();
      end else begin
         // Register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GOAL_X:        goal_x     = csr_wr_data;
               CSR_GOAL_Y:        goal_y     = csr_wr_data;
               CSR_START_X:       start_x    = csr_wr_data;
               CSR_START_Y:       start_y    = csr_wr_data;
               CSR_START_HEADING: start_head = csr_wr_data[HEAD_W-1:0];
               default: ;
            endcase
         end
         // Response transfer first: a request taken this edge cannot answer yet
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.pos_x, rsp.pos_y, rsp.heading, rsp.moved, rsp.at_goal};
            if (walker_q.size() == 0) begin
               report("response transfer with nothing pending");
            end else begin
               want = walker_q.pop_front();
               check_field("pos_x", got.pos_x, want.pos_x);
               check_field("pos_y", got.pos_y, want.pos_y);
               check_field("heading", got.heading, want.heading);
               check_field("moved", got.moved, want.moved);
               check_field("at_goal", got.at_goal, want.at_goal);
            end
         end
         if (req.valid && req.ready) begin
            follow_wall(req.action, req.cell_x, req.cell_y, req.cell_open, want);
            walker_q.push_back(want);
         end
      end
      pending_count <= walker_q.size();
   end

endmodule

[verif/right_hand_wall_follower_test.sv]
module right_hand_wall_follower_test;
   import rhwf_pkg::*;

   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    fail_count;
   int                    pending_count;

   int cycle_count = 0;
   int burst_left  = 0;
   int rx_cycle    = 0;
   int hold_left   = 0;
   bit squeeze_req = 1'b0;
   bit squeeze_done = 1'b0;

   rhwf_req_if req_ch ();
   rhwf_rsp_if rsp_ch ();

   right_hand_wall_follower i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   right_hand_wall_follower_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[right_hand_wall_follower] ERROR");
         $finish;
      end
   end

   // Response side: rotating stall patterns plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (squeeze_req && !squeeze_done) begin
            hold_left    = 80;
            squeeze_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 150) % 4)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ch.ready <= (rx_cycle % 3 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Offer one request in bursts with random gaps; returns at its transfer edge
   task automatic send_item(input logic [1:0] act, input logic [COORD_W-1:0] cx,
                            input logic [COORD_W-1:0] cy, input logic copen);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.cell_x    <= cx;
      req_ch.cell_y    <= cy;
      req_ch.cell_open <= copen;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every response has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [COORD_W-1:0] gx, input logic [COORD_W-1:0] gy,
                                 input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                 input logic [HEAD_W-1:0] sh);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_GOAL_X;
      csr_wr_data <= gx;
      @(posedge clock);
      csr_index   <= CSR_GOAL_Y;
      csr_wr_data <= gy;
      @(posedge clock);
      csr_index   <= CSR_START_X;
      csr_wr_data <= sx;
      @(posedge clock);
      csr_index   <= CSR_START_Y;
      csr_wr_data <= sy;
      @(posedge clock);
      csr_index   <= CSR_START_HEADING;
      csr_wr_data <= CSR_DATA_W'(sh);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Coordinate in an 8x8 window around c; wraps at the grid edges
   function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c);
      return c + COORD_W'($urandom_range(0, 7)) - COORD_W'(3);
   endfunction

   // Build a small maze around the start, restart, then mostly walk it
   task automatic run_phase(input int n, input logic [COORD_W-1:0] gx,
                            input logic [COORD_W-1:0] gy, input logic [COORD_W-1:0] sx,
                            input logic [COORD_W-1:0] sy, input logic [HEAD_W-1:0] sh,
                            input bit squeeze);
      int pick;
      drain();
      write_settings(gx, gy, sx, sy, sh);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (squeeze && i == 60) begin
            squeeze_req <= 1'b1;
         end
         if (i < 36) begin
            send_item(ACT_WRITE, near(sx), near(sy), $urandom_range(0, 9) < 7);
         end else if (i == 36) begin
            send_item(ACT_RESTART, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
         end else if (pick < 65) begin
            send_item(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            send_item(ACT_WRITE, near(sx), near(sy), 1'($urandom));
         end else if (pick < 90) begin
            send_item(ACT_WRITE, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
         end else if (pick < 95) begin
            send_item(ACT_RESTART, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
         end else begin
            send_item(ACT_NONE, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      logic [COORD_W-1:0] rs_x, rs_y;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_WRITE;
      req_ch.cell_x    <= '0;
      req_ch.cell_y    <= '0;
      req_ch.cell_open <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_GOAL_X;
      csr_wr_data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: walker boxed in at the origin, then a short corridor
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_NONE, 5'd31, 5'd31, 1'b1);
      send_item(ACT_WRITE, 5'd0, 5'd1, 1'b1);
      send_item(ACT_WRITE, 5'd1, 5'd1, 1'b1);
      send_item(ACT_WRITE, 5'd2, 5'd1, 1'b1);
      send_item(ACT_WRITE, 5'd2, 5'd2, 1'b1);
      send_item(ACT_RESTART, 5'd31, 5'd31, 1'b1);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd31, 5'd31, 1'b1);
      send_item(ACT_WRITE, 5'd31, 5'd31, 1'b0);

      // Walk onto the goal in the far corner, then step while on it
      drain();
      write_settings(5'd31, 5'd31, 5'd31, 5'd30, HEAD_DOWN);
      send_item(ACT_WRITE, 5'd31, 5'd31, 1'b1);
      send_item(ACT_RESTART, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);

      // Restart right onto the goal at the origin
      drain();
      write_settings(5'd0, 5'd0, 5'd0, 5'd0, HEAD_LEFT);
      send_item(ACT_RESTART, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);

      // Origin facing off the grid, then the far corner facing off the grid
      drain();
      write_settings(5'd5, 5'd5, 5'd0, 5'd0, HEAD_LEFT);
      send_item(ACT_RESTART, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);
      drain();
      write_settings(5'd5, 5'd5, 5'd31, 5'd31, HEAD_RIGHT);
      send_item(ACT_RESTART, 5'd0, 5'd0, 1'b0);
      send_item(ACT_STEP, 5'd0, 5'd0, 1'b0);

      // Random mazes under several register settings
      run_phase(110, 5'd31, 5'd31, 5'd28, 5'd28, HEAD_RIGHT, 1'b0);
      run_phase(110, 5'd0, 5'd0, 5'd3, 5'd3, HEAD_UP, 1'b1);
      for (int p = 0; p < 2; p++) begin
         rs_x = COORD_W'($urandom);
         rs_y = COORD_W'($urandom);
         run_phase(110, near(rs_x), near(rs_y), rs_x, rs_y, HEAD_W'($urandom), 1'b0);
      end
      run_phase(110, 5'd31, 5'd0, 5'd29, 5'd2, HEAD_DOWN, 1'b0);
      run_phase(110, 5'd0, 5'd31, 5'd2, 5'd29, HEAD_LEFT, 1'b0);

      drain();
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[right_hand_wall_follower] OK");
      end else begin
         $display("[right_hand_wall_follower] ERROR");
      end
      $finish;
   end

endmodule

[right_hand_wall_follower.f]
rtl/rhwf_pkg.sv
rtl/rhwf_if.sv
rtl/rhwf_ram.sv
rtl/right_hand_wall_follower.sv
rtl/rhwf_checker.sv
verif/right_hand_wall_follower_checker.sv
verif/right_hand_wall_follower_test.sv
